[rtl/core/multichannel_conv3x3_int16_unit_defines.svh]
// Assertion macros shared by the convolution unit RTL.
// Included by the top level only; no other dependencies.
`ifndef MULTICHANNEL_CONV3X3_INT16_UNIT_DEFINES_SVH
`define MULTICHANNEL_CONV3X3_INT16_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MCC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mcc: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define MCC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mcc: next-cycle check failed");

`endif

[rtl/core/mcc_pkg.sv]
// Shared constants, register codes and cell control type for the 3x3 conv unit.
// No dependencies; used by mcc_cell and the top-level module in rtl/core.
`timescale 1ns / 1ps

package mcc_pkg;

    // Arithmetic and kernel geometry
    localparam int DATA_W         = 16;
    localparam int KERNEL_SIZE    = 3;
    localparam int TAPS           = KERNEL_SIZE * KERNEL_SIZE;
    localparam int MAX_CHANNELS   = 3;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_CHANNELS   = 3;

    // Configuration port
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;
    localparam int COEF_PER_GROUP = CFG_DATA_W / DATA_W;
    localparam int ROW_WIDTH_W    = 9;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 9'd256;

    // Row counter saturates once two full rows sit in the line buffer
    localparam int ROW_CNT_W = 2;
    localparam logic [ROW_CNT_W-1:0] ROW_FULL = 2'd2;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_GROUP_0,
        REG_COEF_GROUP_1,
        REG_COEF_GROUP_2,
        REG_COEF_GROUP_3,
        REG_COEF_GROUP_4,
        REG_COEF_GROUP_5,
        REG_COEF_GROUP_6,
        REG_ROW_WIDTH
    } mcc_reg_e;

    // Per-cycle enables handed to every window cell
    typedef struct packed {
        logic shift_en;
        logic prod_en;
        logic sum_en;
    } mcc_cell_ctrl_t;

endpackage

[rtl/core/mcc_line_buf.sv]
// Two-row line buffer: each memory word holds one column of the previous row and of the one before it.
// Depends on nothing but its parameters; instantiated by the top level.
`timescale 1ns / 1ps

module mcc_line_buf #(
    parameter int DEPTH = 258,
    parameter int AW    = 9,
    parameter int DW    = 96
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write the retiring column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data; forward a write to the same address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mcc_cell.sv]
// One window column cell: holds a column of pixels, multiplies it by its
// coefficients and reduces the products. Depends on mcc_pkg.
`timescale 1ns / 1ps

module mcc_cell #(
    parameter int CHANNELS = mcc_pkg::DEF_CHANNELS
) (
    input  logic                   clk,
    input  mcc_pkg::mcc_cell_ctrl_t ctrl,
    input  logic [mcc_pkg::KERNEL_SIZE-1:0][CHANNELS-1:0][mcc_pkg::DATA_W-1:0] col_in,
    input  logic [mcc_pkg::KERNEL_SIZE-1:0][CHANNELS-1:0][mcc_pkg::DATA_W-1:0] coef,
    output logic [mcc_pkg::KERNEL_SIZE-1:0][CHANNELS-1:0][mcc_pkg::DATA_W-1:0] col_out,
    output logic [mcc_pkg::DATA_W-1:0]                                          psum
);

    localparam int KS = mcc_pkg::KERNEL_SIZE;
    localparam int DW = mcc_pkg::DATA_W;

    logic [KS-1:0][CHANNELS-1:0][DW-1:0] col_reg;
    logic [KS-1:0][CHANNELS-1:0][DW-1:0] prod_reg;
    logic [KS-1:0][CHANNELS-1:0][DW-1:0] prod_next;
    logic [DW-1:0]                       psum_reg;
    logic [DW-1:0]                       psum_next;

    // Shift the column in from the neighbor
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // Truncated products, one per row and channel
    always_comb
    begin
        for (int r = 0; r < KS; r++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                prod_next[r][ch] = DW'(col_reg[r][ch] * coef[r][ch]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Reduce the column's products, wrapping at the data width
    always_comb
    begin
        psum_next = '0;
        for (int r = 0; r < KS; r++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                psum_next = psum_next + prod_reg[r][ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            psum_reg <= psum_next;
        end
    end

    assign psum = psum_reg;

endmodule

[rtl/core/multichannel_conv3x3_int16_unit.sv]
// 3x3 multichannel cross-correlation, 16-bit wrapping; uses mcc_pkg, mcc_cell, mcc_line_buf.
// Results pass stages A (line read), W (window), P (products), S (sums) and O to result_valid.
// Throughput: one sample per cycle, set by the single write/read line buffer and the column cells,
// unless a waiting result has filled every stage: stages move up into empty slots while it waits.
// Reset clears control state, coefficients to zero and row_width to 256; line buffer is not cleared.
`timescale 1ns / 1ps
`include "multichannel_conv3x3_int16_unit_defines.svh"

module multichannel_conv3x3_int16_unit #(
    parameter int MAX_WIDTH = mcc_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS  = mcc_pkg::DEF_CHANNELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [mcc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mcc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [mcc_pkg::DATA_W-1:0]    sample_ch0,
    input  logic signed [mcc_pkg::DATA_W-1:0]    sample_ch1,
    input  logic signed [mcc_pkg::DATA_W-1:0]    sample_ch2,
    input  logic                                 frame_start,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [mcc_pkg::DATA_W-1:0]    result,
    output logic                                 row_end
);

    localparam int DW    = mcc_pkg::DATA_W;
    localparam int KS    = mcc_pkg::KERNEL_SIZE;
    localparam int TAPS  = mcc_pkg::TAPS;
    localparam int DEPTH = MAX_WIDTH + KS - 1;
    localparam int XW    = $clog2(DEPTH);
    localparam int CW    = ((XW > mcc_pkg::ROW_WIDTH_W) ? XW : mcc_pkg::ROW_WIDTH_W) + 1;
    localparam int PW    = CHANNELS * DW;
    localparam int NCOEF = CHANNELS * TAPS;
    localparam int RW    = mcc_pkg::ROW_WIDTH_W;
    localparam int RCW   = mcc_pkg::ROW_CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NCOEF-1:0][DW-1:0] coef_reg;
    logic [RW-1:0]            row_width_reg;

    genvar n;
    generate
        for (n = 0; n < NCOEF; n++)
        begin : g_coef
            localparam int GRP = n / mcc_pkg::COEF_PER_GROUP;
            localparam int SUB = n % mcc_pkg::COEF_PER_GROUP;

            // Load one coefficient from its group word
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    coef_reg[n] <= '0;
                end
                else if (cfg_wr_en && (cfg_index ==
                         mcc_pkg::CFG_INDEX_W'(int'(mcc_pkg::REG_COEF_GROUP_0) + GRP)))
                begin
                    coef_reg[n] <= cfg_data[DW*SUB +: DW];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= mcc_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_wr_en && (cfg_index == mcc_pkg::REG_ROW_WIDTH))
        begin
            row_width_reg <= cfg_data[RW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: each stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic a_valid_reg, w_valid_reg, p_valid_reg, s_valid_reg, out_valid_reg;
    logic en_a, en_w, en_p, en_s, en_o;
    logic accept;

    assign en_o   = !out_valid_reg || result_ready;
    assign en_s   = !s_valid_reg || en_o;
    assign en_p   = !p_valid_reg || en_s;
    assign en_w   = !w_valid_reg || en_p;
    assign en_a   = !a_valid_reg || en_w;
    assign accept = sample_valid && en_a;

    assign sample_ready = en_a;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [XW-1:0]  column_count_reg, column_count_next;
    logic [RCW-1:0] row_count_reg, row_count_next;
    logic [XW-1:0]  x_acc;
    logic [RCW-1:0] rc_acc;
    logic [CW-1:0]  w_lim, x_end, x_ext;
    logic           last_acc, emit_acc, rend_acc;

    always_comb
    begin
        x_acc  = frame_start ? '0 : column_count_reg;
        rc_acc = frame_start ? '0 : row_count_reg;
        // Clamp the row width to MAX_WIDTH
        w_lim  = (CW'(row_width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(row_width_reg);
        x_end  = w_lim + CW'(KS - 2);
        x_ext  = CW'(x_acc);

        last_acc = (x_ext >= x_end);
        emit_acc = (rc_acc == mcc_pkg::ROW_FULL) && (x_ext >= CW'(KS - 1)) && (x_ext <= x_end);
        rend_acc = (x_ext == x_end);

        column_count_next = last_acc ? '0 : (x_acc + XW'(1));
        row_count_next    = (last_acc && (rc_acc != mcc_pkg::ROW_FULL)) ?
                            (rc_acc + RCW'(1)) : rc_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: sample held while the line buffer word is read
    // ------------------------------------------------------------------
    logic [2:0][DW-1:0]            samples_all;
    logic [CHANNELS-1:0][DW-1:0]   px_acc;
    logic [CHANNELS-1:0][DW-1:0]   a_px_reg;
    logic [XW-1:0]                 a_x_reg;
    logic                          a_emit_reg, a_rend_reg;
    logic [2*PW-1:0]               lb_rd_data;
    logic [CHANNELS-1:0][DW-1:0]   up1, up2;

    assign samples_all = {sample_ch2, sample_ch1, sample_ch0};

    genvar ch;
    generate
        for (ch = 0; ch < CHANNELS; ch++)
        begin : g_px
            assign px_acc[ch] = samples_all[ch];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en_a)
        begin
            a_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_px_reg   <= px_acc;
            a_x_reg    <= x_acc;
            a_emit_reg <= emit_acc;
            a_rend_reg <= rend_acc;
        end
    end

    // Low half: previous row; high half: row before it
    assign up1 = lb_rd_data[PW-1:0];
    assign up2 = lb_rd_data[2*PW-1:PW];

    mcc_line_buf #(
        .DEPTH (DEPTH),
        .AW    (XW),
        .DW    (2 * PW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (a_valid_reg && en_w),
        .wr_addr (a_x_reg),
        .wr_data ({up1, a_px_reg}),
        .rd_en   (accept),
        .rd_addr (x_acc),
        .rd_data (lb_rd_data)
    );

    // ------------------------------------------------------------------
    // Stages W, P, S: window shift, products, column sums in the cell chain
    // ------------------------------------------------------------------
    logic                    w_rend_reg, p_rend_reg, s_rend_reg;
    mcc_pkg::mcc_cell_ctrl_t cell_ctrl;

    assign cell_ctrl.shift_en = a_valid_reg && en_w;
    assign cell_ctrl.prod_en  = w_valid_reg && en_p;
    assign cell_ctrl.sum_en   = p_valid_reg && en_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_w)
            begin
                w_valid_reg <= a_valid_reg && a_emit_reg;
            end
            if (en_p)
            begin
                p_valid_reg <= w_valid_reg;
            end
            if (en_s)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    // Carry the row-end flag alongside the data
    always_ff @(posedge clk)
    begin
        if (cell_ctrl.shift_en)
        begin
            w_rend_reg <= a_rend_reg;
        end
        if (cell_ctrl.prod_en)
        begin
            p_rend_reg <= w_rend_reg;
        end
        if (cell_ctrl.sum_en)
        begin
            s_rend_reg <= p_rend_reg;
        end
    end

    logic [KS-1:0][KS-1:0][CHANNELS-1:0][DW-1:0] col_chain;
    logic [KS-1:0][KS-1:0][CHANNELS-1:0][DW-1:0] col_feed;
    logic [KS-1:0][KS-1:0][CHANNELS-1:0][DW-1:0] cell_coef;
    logic [KS-1:0][DW-1:0]                       col_sum;

    genvar c, r;
    generate
        for (c = 0; c < KS; c++)
        begin : g_cell
            // Route coefficient channel*9 + row*3 + column to its cell
            for (r = 0; r < KS; r++)
            begin : g_row
                for (ch = 0; ch < CHANNELS; ch++)
                begin : g_ch
                    assign cell_coef[c][r][ch] = coef_reg[ch*TAPS + r*KS + c];
                end
            end

            // Newest column enters at the top cell; older columns pass down
            if (c == KS - 1)
            begin : g_head
                assign col_feed[c][0]      = up2;
                assign col_feed[c][1]      = up1;
                assign col_feed[c][KS - 1] = a_px_reg;
            end
            else
            begin : g_link
                assign col_feed[c] = col_chain[c + 1];
            end

            mcc_cell #(
                .CHANNELS (CHANNELS)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .col_in  (col_feed[c]),
                .coef    (cell_coef[c]),
                .col_out (col_chain[c]),
                .psum    (col_sum[c])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage O: final sum into the output register
    // ------------------------------------------------------------------
    logic [DW-1:0] result_reg, result_next;
    logic          row_end_reg;

    always_comb
    begin
        result_next = '0;
        for (int k = 0; k < KS; k++)
        begin
            result_next = result_next + col_sum[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_o)
        begin
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o && s_valid_reg)
        begin
            result_reg  <= result_next;
            row_end_reg <= s_rend_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;
    assign row_end      = row_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MCC_ASSERT_NOW(a_row_count_sat, clk, rst_n, 1'b1, row_count_reg <= mcc_pkg::ROW_FULL)
    `MCC_ASSERT_NOW(a_col_in_range, clk, rst_n, 1'b1, column_count_reg <= XW'(DEPTH - 1))
    `MCC_ASSERT_NEXT(a_accept_fills_a, clk, rst_n, sample_valid && sample_ready, a_valid_reg)
    `MCC_ASSERT_NEXT(a_window_holds, clk, rst_n, w_valid_reg && !en_p, w_valid_reg)

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 multichannel int16 convolution unit.
// Depends on mcc_pkg and multichannel_conv3x3_int16_unit; runs a directed table, then
// random frames, and compares each result transaction against a built-in predictor or a table value.

module tb_top;

    import mcc_pkg::*;

    localparam int LINE_DEPTH     = DEF_MAX_WIDTH + 2;
    localparam int NUM_COEF       = MAX_CHANNELS * TAPS;
    localparam int SETTLE_CYCLES  = 12;
    localparam int IDLE_PCT       = 22;
    localparam int CALM_FROM      = 1200;
    localparam int CALM_TO        = 1900;
    localparam int HOLD_AFTER     = 30;
    localparam int HOLD_CYCLES    = 250;
    localparam int RANDOM_PIXELS  = 1350;
    localparam int N_DIR          = 29;

    typedef enum logic [0:0] {STEP_WRITE, STEP_PIXEL} step_kind_e;
    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_GIVEN} outcome_e;
    typedef enum logic [2:0] {
        CM_RANDOM,
        CM_POS_MAX,
        CM_NEG_MAX,
        CM_MINUS_ONE,
        CM_DROP_CH2
    } coef_mode_e;

    // One directed step: a register write or a pixel ({ch2, ch1, ch0}) with its outcome
    typedef struct packed {
        step_kind_e  kind;
        mcc_reg_e    addr;
        logic [63:0] wdata;
        logic [47:0] pix;
        logic        fs;
        outcome_e    how;
        logic [15:0] res;
        logic        last;
    } dir_step_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_col;
    } conv_out_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                           cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]         cfg_index    = '0;
    logic [CFG_DATA_W-1:0]          cfg_data     = '0;
    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    logic signed [DATA_W-1:0]       sample_ch0   = '0;
    logic signed [DATA_W-1:0]       sample_ch1   = '0;
    logic signed [DATA_W-1:0]       sample_ch2   = '0;
    logic                           frame_start  = 1'b0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic signed [DATA_W-1:0]       result;
    logic                           row_end;

    // Predictor state
    logic [15:0]            kern_coef [NUM_COEF];
    logic [ROW_WIDTH_W-1:0] cols_setting;
    logic [47:0]            line_prev [LINE_DEPTH];
    logic [47:0]            line_older [LINE_DEPTH];
    logic [47:0]            win_px [TAPS];
    int unsigned            col_pos;
    int unsigned            rows_seen;

    conv_out_t   expected_q [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          random_fed   = 0;
    int unsigned cycle_cnt    = 0;

    dir_step_t dir_table [N_DIR] = '{
        '{STEP_WRITE, REG_ROW_WIDTH, 64'd2, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        // two fill rows, four padded pixels each
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h0000_7fff_8000, 1'b1, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h7fff_8000_ffff, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h8000_ffff_0000, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'hffff_0000_7fff, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h8001_fffe_0001, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h0001_8001_fffe, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'hfffe_0001_8001, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h5555_aaaa_5555, 1'b0, OUT_NONE, 16'h0, 1'b0},
        // reset coefficients are zero, so every output is zero
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'haaaa_5555_aaaa, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h7fff_7fff_7fff, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h8000_8000_8000, 1'b0, OUT_GIVEN, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'hffff_ffff_ffff, 1'b0, OUT_GIVEN, 16'h0, 1'b1},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h0000_0000_0000, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h1234_5678_9abc, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h8000_7fff_8000, 1'b0, OUT_GIVEN, 16'h0, 1'b0},
        // all coefficients -1, ignored top of the last group included
        '{STEP_WRITE, REG_COEF_GROUP_0, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_1, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_2, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_3, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_4, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_5, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_WRITE, REG_COEF_GROUP_6, 64'hffffffffffffffff, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        // shrink the width mid-row: the next pixel closes the row without output
        '{STEP_WRITE, REG_ROW_WIDTH, 64'd1, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h0f0f_f0f0_0f0f, 1'b0, OUT_NONE, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h7fff_0000_8000, 1'b0, OUT_MODEL, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'hc3c3_3c3c_0001, 1'b0, OUT_MODEL, 16'h0, 1'b0},
        '{STEP_PIXEL, REG_ROW_WIDTH, 64'd0, 48'h8000_ffff_7fff, 1'b0, OUT_MODEL, 16'h0, 1'b0},
        // zero width never produces output
        '{STEP_WRITE, REG_ROW_WIDTH, 64'd0, 48'h0, 1'b0, OUT_NONE, 16'h0, 1'b0}
    };

    multichannel_conv3x3_int16_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_ch0   (sample_ch0),
        .sample_ch1   (sample_ch1),
        .sample_ch2   (sample_ch2),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .row_end      (row_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Idle at random outside the calm stretch
    function automatic bit idle_now();
        return (cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) &&
               ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Favor the extremes of the 16-bit range
    function automatic logic [15:0] rand_px();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] coef_group(input coef_mode_e mode, input int g);
        logic [63:0] val;
        logic [15:0] c;
        int          k;
        int          n;
        for (k = 0; k < COEF_PER_GROUP; k++)
        begin
            n = g * COEF_PER_GROUP + k;
            case (mode)
                CM_POS_MAX:   c = 16'h7fff;
                CM_NEG_MAX:   c = 16'h8000;
                CM_MINUS_ONE: c = 16'hffff;
                default:      c = 16'($urandom);
            endcase
            // silence channel 2; unused slot past the last coefficient stays random
            if (mode == CM_DROP_CH2 && n >= 2 * TAPS && n < NUM_COEF)
                c = '0;
            if (n >= NUM_COEF)
                c = 16'($urandom);
            val[16*k +: 16] = c;
        end
        return val;
    endfunction

    // Mirror a register write into the predictor
    function automatic void load_reg(input mcc_reg_e idx, input logic [63:0] val);
        int k;
        int n;
        if (idx == REG_ROW_WIDTH)
            cols_setting = val[ROW_WIDTH_W-1:0];
        else
        begin
            for (k = 0; k < COEF_PER_GROUP; k++)
            begin
                n = int'(idx) * COEF_PER_GROUP + k;
                if (n < NUM_COEF)
                    kern_coef[n] = val[16*k +: 16];
            end
        end
    endfunction

    // Sum of truncated 16-bit products over the window, wrapping
    function automatic logic [15:0] window_sum();
        logic [15:0] acc;
        logic [15:0] prod;
        int          ch;
        int          t;
        acc = '0;
        for (ch = 0; ch < DEF_CHANNELS; ch++)
        begin
            for (t = 0; t < TAPS; t++)
            begin
                prod = kern_coef[ch*TAPS + t] * win_px[t][16*ch +: 16];
                acc  = acc + prod;
            end
        end
        return acc;
    endfunction

    // Advance the predictor by one accepted pixel
    task automatic step_model(input logic [47:0] px, input bit fs, output bit has,
                              output logic [15:0] sum, output bit last_col);
        int unsigned w;
        int unsigned padded;
        int unsigned x;
        logic [47:0] up1;
        logic [47:0] up2;
        int          r;
        if (fs)
        begin
            col_pos   = 0;
            rows_seen = 0;
        end
        w      = (cols_setting > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cols_setting;
        padded = w + 2;
        x      = col_pos;
        up1    = '0;
        up2    = '0;
        if (x < LINE_DEPTH)
        begin
            up1           = line_prev[x];
            up2           = line_older[x];
            line_older[x] = up1;
            line_prev[x]  = px;
        end
        for (r = 0; r < 3; r++)
        begin
            win_px[3*r]     = win_px[3*r + 1];
            win_px[3*r + 1] = win_px[3*r + 2];
        end
        win_px[2] = up2;
        win_px[5] = up1;
        win_px[8] = px;
        has      = (rows_seen >= 2) && (x >= 2) && (x <= padded - 1);
        last_col = (x == padded - 1);
        if (x >= padded - 1)
        begin
            col_pos = 0;
            if (rows_seen < 2)
                rows_seen++;
        end
        else
            col_pos = x + 1;
        sum = has ? window_sum() : '0;
    endtask

    // Write one register while the unit is idle
    task automatic write_reg(input mcc_reg_e idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        load_reg(idx, val);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline drain
    task automatic settle();
        sample_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one pixel transaction and queue what it should produce
    task automatic offer_pixel(input logic [47:0] px, input bit fs, input outcome_e how,
                               input logic [15:0] g_res, input bit g_end);
        bit          has;
        logic [15:0] sum;
        bit          last_col;
        while (idle_now())
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_ch0   <= px[15:0];
        sample_ch1   <= px[31:16];
        sample_ch2   <= px[47:32];
        frame_start  <= fs;
        do
            @(posedge clk);
        while (!sample_ready);
        step_model(px, fs, has, sum, last_col);
        if (how == OUT_GIVEN)
        begin
            has      = 1'b1;
            sum      = g_res;
            last_col = g_end;
        end
        else if (how == OUT_NONE)
            has = 1'b0;
        if (has)
            expected_q.push_back('{sum, last_col});
    endtask

    // Reprogram the kernel and width, then stream random pixels
    task automatic run_phase(input logic [ROW_WIDTH_W-1:0] width, input int count,
                             input bit keep_frame, input coef_mode_e mode);
        logic [63:0] wd;
        int          g;
        int          i;
        bit          fs;
        settle();
        for (g = 0; g < int'(REG_ROW_WIDTH); g++)
            write_reg(mcc_reg_e'(g), coef_group(mode, g));
        wd = {$urandom, $urandom};
        wd[ROW_WIDTH_W-1:0] = width;
        write_reg(REG_ROW_WIDTH, wd);
        for (i = 0; i < count; i++)
        begin
            if (i == 0)
                fs = !keep_frame;
            else
                fs = (width <= 16) && ($urandom_range(99) < 3);
            offer_pixel({rand_px(), rand_px(), rand_px()}, fs, OUT_MODEL, '0, 1'b0);
            random_fed++;
        end
    endtask

    // Result side: random stalls plus one long hold-off to back the unit up
    initial
    begin : result_sink
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ready <= !idle_now();
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        conv_out_t exp_out;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d row_end %0b",
                         $time, result, row_end);
                mismatches++;
            end
            else
            begin
                exp_out = expected_q.pop_front();
                if (result !== exp_out.value)
                begin
                    $display("%0t: result mismatch: expected %0d, actual %0d",
                             $time, exp_out.value, result);
                    mismatches++;
                end
                if (row_end !== exp_out.last_col)
                begin
                    $display("%0t: row_end mismatch: expected %0b, actual %0b",
                             $time, exp_out.last_col, row_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        // predictor reset state
        for (i = 0; i < LINE_DEPTH; i++)
        begin
            line_prev[i]  = '0;
            line_older[i] = '0;
        end
        for (i = 0; i < TAPS; i++)
            win_px[i] = '0;
        for (i = 0; i < NUM_COEF; i++)
            kern_coef[i] = '0;
        cols_setting = ROW_WIDTH_RESET;
        col_pos      = 0;
        rows_seen    = 0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < N_DIR; i++)
        begin
            if (dir_table[i].kind == STEP_WRITE)
            begin
                settle();
                write_reg(dir_table[i].addr, dir_table[i].wdata);
            end
            else
                offer_pixel(dir_table[i].pix, dir_table[i].fs, dir_table[i].how,
                            dir_table[i].res, dir_table[i].last);
        end
        for (i = 0; i < 3; i++)
            offer_pixel({rand_px(), rand_px(), rand_px()}, i == 0, OUT_NONE, '0, 1'b0);

        // Random frames: small widths, one full-width frame continued at an oversized width
        run_phase(9'd1, 60, 1'b0, CM_RANDOM);
        run_phase(9'd3, 80, 1'b0, CM_DROP_CH2);
        run_phase(9'd256, 780, 1'b0, CM_RANDOM);
        run_phase(9'd511, 90, 1'b1, CM_NEG_MAX);
        run_phase(9'd0, 20, 1'b0, CM_POS_MAX);
        run_phase(9'd2, 40, 1'b0, CM_MINUS_ONE);
        while (random_fed < RANDOM_PIXELS)
            run_phase(9'($urandom_range(1, 12)), $urandom_range(30, 70), 1'b0,
                      coef_mode_e'($urandom_range(int'(CM_DROP_CH2))));

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[multichannel_conv3x3_int16_unit.f]
+incdir+rtl/core
rtl/core/mcc_pkg.sv
rtl/core/mcc_line_buf.sv
rtl/core/mcc_cell.sv
rtl/core/multichannel_conv3x3_int16_unit.sv
bench/tb_top.sv
